// ===== rtl/kdpl_pkg.sv =====
// kdpl_pkg: shared types, codes and helpers for the kd partition locator.
// No dependencies; imported by every module under rtl/.
package kdpl_pkg;

  localparam int NODES_DEF     = 1024;
  localparam int MAX_DEPTH_DEF = 32;

  localparam int IDX_W    = 10;   // width of node_addr, node_link and partition
  localparam int CFG_W    = 11;
  localparam int IN_TDATA_W  = 184;
  localparam int OUT_TDATA_W = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [2:0] AXIS_X = 3'd0;
  localparam logic [2:0] AXIS_Y = 3'd1;
  localparam logic [2:0] AXIS_Z = 3'd2;
  localparam logic [2:0] AXIS_U = 3'd3;
  localparam logic [2:0] AXIS_V = 3'd4;

  typedef struct packed {
    logic              leaf;
    logic [2:0]        axis;
    logic signed [31:0] split;
    logic [IDX_W-1:0]  link;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic [15:0]        dir_v;
    logic [15:0]        dir_u;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } query_t;

  // tdata layout of an input item, first field in the highest bits
  typedef struct packed {
    query_t             query;
    logic [IDX_W-1:0]   node_link;
    logic signed [31:0] node_split;
    logic [2:0]         node_axis;
    logic               node_is_leaf;
    logic [IDX_W-1:0]   node_addr;
  } in_data_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] partition;
    logic             overrun;
  } walk_res_t;

  typedef struct packed {
    logic busy;
    logic walking;
  } walk_stat_t;

  // v mod m for a 10-bit v, by restoring reduction against shifted copies of m
  function automatic logic [IDX_W-1:0] reduce_mod(input logic [IDX_W-1:0] v,
                                                  input int unsigned m);
    logic [31:0] r;
    logic [31:0] lim;
    r = {{(32-IDX_W){1'b0}}, v};
    for (int k = IDX_W - 1; k >= 0; k--) begin
      lim = m << k;
      if (lim < (32'd1 << IDX_W) && r >= lim) begin
        r = r - lim;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/kd_partition_locate.sv =====
// kd_partition_locate: kd partition tree point locator, top level.
// Depends on kdpl_pkg, kdpl_node_mem and kdpl_walker.
//
// channel   dir   handshake          payload
// s_*       in    tvalid/tready      tuser: action; tdata: node write or query
// m_*       out   tvalid/tready      tuser: walk_overrun; tdata: partition
// cfg_*     in    cfg_wen            cfg_wdata: node_count
//
// A query walks one node per read of the node memory and visits at most
// MAX_DEPTH+1 nodes. An empty tree answers without a node read.
// rst clears control only; node memory contents are undefined until written.
// The next item is taken while the result register still waits on m_tready;
// only the handoff into that register stalls.
module kd_partition_locate #(
  parameter int NODES     = kdpl_pkg::NODES_DEF,
  parameter int MAX_DEPTH = kdpl_pkg::MAX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // node_addr, node_is_leaf, node_axis, node_split, node_link,
  // pos_x, pos_y, pos_z, dir_u, dir_v
  input  logic [kdpl_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                               s_tuser,   // action
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [kdpl_pkg::OUT_TDATA_W-1:0]   m_tdata,   // partition, zero pad
  output logic                               m_tuser,   // walk_overrun
  input  logic                               cfg_wen,
  input  logic [kdpl_pkg::CFG_W-1:0]         cfg_wdata  // node_count
);
  import kdpl_pkg::*;

  localparam int AW = $clog2(NODES);

  in_data_t        din;
  logic            s_acc;
  logic            node_wr_en;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   wr_child;
  node_t           wr_node;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  node_t           rd_node;
  logic [AW-1:0]   rd_child;
  walk_res_t       walk_res;
  walk_stat_t      walk_stat;
  logic            res_ready;
  logic [CFG_W-1:0] node_count;
  logic [IDX_W-1:0] out_part;
  logic            out_ovr;

  assign din        = in_data_t'(s_tdata);
  assign s_tready   = !walk_stat.busy;
  assign s_acc      = s_tvalid && s_tready;
  assign node_wr_en = s_acc && (s_tuser == ACT_WRITE);

  // addresses and right-child links wrap modulo NODES; the child is kept
  // reduced in memory so the walk loop stays short
  assign wr_addr       = AW'(reduce_mod(din.node_addr, NODES));
  assign wr_child      = AW'(reduce_mod(din.node_link, NODES));
  assign wr_node.leaf  = din.node_is_leaf;
  assign wr_node.axis  = din.node_axis;
  assign wr_node.split = din.node_split;
  assign wr_node.link  = din.node_link;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_wen) begin
      node_count <= cfg_wdata;
    end
  end

  kdpl_node_mem #(
    .DEPTH (NODES),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (node_wr_en),
    .wr_addr  (wr_addr),
    .wr_node  (wr_node),
    .wr_child (wr_child),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_node  (rd_node),
    .rd_child (rd_child)
  );

  kdpl_walker #(
    .NODES     (NODES),
    .MAX_DEPTH (MAX_DEPTH),
    .AW        (AW)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .start     (s_acc && (s_tuser == ACT_QUERY)),
    .empty     (node_count == '0),
    .query     (din.query),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_node   (rd_node),
    .rd_child  (rd_child),
    .res       (walk_res),
    .res_ready (res_ready),
    .stat      (walk_stat)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= walk_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && walk_res.valid) begin
      out_part <= walk_res.partition;
      out_ovr  <= walk_res.overrun;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-IDX_W){1'b0}}, out_part};
  assign m_tuser = out_ovr;

`ifndef SYNTHESIS
  // the node memory is never written under a walk in flight
  a_no_write_in_walk: assert property (@(posedge clk) disable iff (rst)
    node_wr_en |-> !walk_stat.busy)
    else $error("node write while walk busy");

  // an empty tree answers partition 0 without overrun on the next cycle
  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser == ACT_QUERY && node_count == '0) |=>
      (walk_res.valid && walk_res.partition == '0 && !walk_res.overrun))
    else $error("empty tree query gave wrong result");

  // an overrun result never carries a partition
  a_overrun_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[IDX_W-1:0] == '0))
    else $error("overrun result with nonzero partition");

  // a finished walk leaves the read port quiet
  a_no_read_after_walk: assert property (@(posedge clk) disable iff (rst)
    walk_res.valid |-> !rd_en)
    else $error("node read while result pending");
`endif

endmodule

// ===== rtl/kdpl_node_mem.sv =====
// kdpl_node_mem: simple dual-port node memory, one write and one read per cycle,
// registered read data. Depends on kdpl_pkg for node_t.
module kdpl_node_mem #(
  parameter int DEPTH = kdpl_pkg::NODES_DEF,
  parameter int AW    = $clog2(kdpl_pkg::NODES_DEF)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  kdpl_pkg::node_t     wr_node,
  input  logic [AW-1:0]       wr_child,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output kdpl_pkg::node_t     rd_node,
  output logic [AW-1:0]       rd_child
);
  import kdpl_pkg::*;

  localparam int EW = NODE_W + AW;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_child, wr_node};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign rd_node  = node_t'(rdata[NODE_W-1:0]);
  assign rd_child = rdata[EW-1:NODE_W];

endmodule

// ===== rtl/kdpl_walker.sv =====
// kdpl_walker: query sequencer, one node read per cycle down the tree.
// Depends on kdpl_pkg; drives the read port of kdpl_node_mem.
module kdpl_walker #(
  parameter int NODES     = kdpl_pkg::NODES_DEF,
  parameter int MAX_DEPTH = kdpl_pkg::MAX_DEPTH_DEF,
  parameter int AW        = $clog2(kdpl_pkg::NODES_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 empty,
  input  kdpl_pkg::query_t     query,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  kdpl_pkg::node_t      rd_node,
  input  logic [AW-1:0]        rd_child,
  output kdpl_pkg::walk_res_t  res,
  input  logic                 res_ready,
  output kdpl_pkg::walk_stat_t stat
);
  import kdpl_pkg::*;

  localparam int SW = $clog2(MAX_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state, state_next;
  logic [AW-1:0]    idx;
  logic [AW-1:0]    idx_inc;
  logic [AW-1:0]    idx_step;
  logic [SW-1:0]    steps;
  query_t           q;
  logic [IDX_W-1:0] res_part;
  logic             res_ovr;
  logic signed [32:0] test_val;
  logic signed [32:0] split_val;
  logic             at_limit;

  always_comb begin
    case (rd_node.axis)
      AXIS_X:  test_val = {q.pos_x[31], q.pos_x};
      AXIS_Y:  test_val = {q.pos_y[31], q.pos_y};
      AXIS_Z:  test_val = {q.pos_z[31], q.pos_z};
      AXIS_U:  test_val = {1'b0, q.dir_u, 16'h0000};
      AXIS_V:  test_val = {1'b0, q.dir_v, 16'h0000};
      default: test_val = '0;
    endcase
  end

  assign split_val = {rd_node.split[31], rd_node.split};
  assign idx_inc   = (idx == AW'(NODES - 1)) ? '0 : idx + 1'b1;
  assign idx_step  = (test_val > split_val) ? rd_child : idx_inc;
  assign at_limit  = (steps == SW'(MAX_DEPTH));

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          rd_en      = !empty;
          state_next = empty ? S_FIN : S_WALK;
        end
      end
      S_WALK: begin
        if (rd_node.leaf || at_limit) begin
          state_next = S_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_step;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          q        <= query;
          idx      <= '0;
          steps    <= '0;
          res_part <= '0;
          res_ovr  <= 1'b0;
        end
      end
      S_WALK: begin
        if (rd_node.leaf) begin
          res_part <= rd_node.link;
          res_ovr  <= 1'b0;
        end else if (at_limit) begin
          res_part <= '0;
          res_ovr  <= 1'b1;
        end else begin
          idx   <= idx_step;
          steps <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.valid     = (state == S_FIN);
  assign res.partition = res_part;
  assign res.overrun   = res_ovr;
  assign stat.busy     = (state != S_IDLE);
  assign stat.walking  = (state == S_WALK);

endmodule
